// File: rtl/priority_sorted_round_robin_scheduler_core_assert.svh
// ---------------------------------------------------------------------------
// Scheduler assertion macros
// Concurrent check wrappers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef PRIORITY_SORTED_ROUND_ROBIN_SCHEDULER_CORE_ASSERT_SVH
`define PRIORITY_SORTED_ROUND_ROBIN_SCHEDULER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define PSRR_ASSERT_IMP(lbl, c, r, pre, post) \
	lbl: assert property (@(posedge c) disable iff (!r) (pre) |-> (post)) \
		else $error("scheduler check failed");
`define PSRR_ASSERT_NXT(lbl, c, r, pre, post) \
	lbl: assert property (@(posedge c) disable iff (!r) (pre) |=> (post)) \
		else $error("scheduler check failed");
`else
`define PSRR_ASSERT_IMP(lbl, c, r, pre, post)
`define PSRR_ASSERT_NXT(lbl, c, r, pre, post)
`endif

`endif

// File: rtl/psrr_pkg.sv
// ---------------------------------------------------------------------------
// Scheduler package
// Opcodes, task status codes, field widths and the table entry layout.
// ---------------------------------------------------------------------------
package psrr_pkg;

	localparam int MAX_TASKS_DEF = 8;
	localparam int PRIO_BITS     = 8;
	localparam int TAG_BITS      = 32;
	localparam int SLOT_BITS     = 3;

	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_SET   = 2'd1;
	localparam logic [1:0] OP_START = 2'd2;
	localparam logic [1:0] OP_TICK  = 2'd3;

	localparam logic [1:0] ST_BLOCKED = 2'd0;
	localparam logic [1:0] ST_READY   = 2'd1;
	localparam logic [1:0] ST_RUNNING = 2'd2;

	typedef struct packed {
		logic [PRIO_BITS-1:0] prio;
		logic [TAG_BITS-1:0]  tag;
	} dent_t;

endpackage

// File: rtl/priority_sorted_round_robin_scheduler_core.sv
// ---------------------------------------------------------------------------
// Priority-sorted round-robin scheduler core
// Add and set status go from idle straight to the response state. Tick marks the current slot ready,
// then checks up to N slots from the next one. Start: each bubble pass reads, loads, does L compares and
// writes the last entry; a slot scan from the current slot follows. Each memory is 1R1W; one beat at a time.
// arst_n clears task count, current slot, started flag and control; tables are not cleared.
// ---------------------------------------------------------------------------
`include "priority_sorted_round_robin_scheduler_core_assert.svh"

module priority_sorted_round_robin_scheduler_core
	import psrr_pkg::*;
#(
	parameter int MAX_TASKS = MAX_TASKS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           opcode,
	input  logic [SLOT_BITS-1:0] slot,
	input  logic [PRIO_BITS-1:0] priority_req,
	input  logic [1:0]           task_status,
	input  logic [TAG_BITS-1:0]  task_tag,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 ok,
	output logic                 none_ready,
	output logic [SLOT_BITS-1:0] running_slot,
	output logic [TAG_BITS-1:0]  running_tag
);

	localparam int IW = $clog2(MAX_TASKS);
	localparam int CW = $clog2(MAX_TASKS + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SRD0  = 3'd1;
	localparam logic [2:0] S_SLOAD = 3'd2;
	localparam logic [2:0] S_SCMP  = 3'd3;
	localparam logic [2:0] S_SEND  = 3'd4;
	localparam logic [2:0] S_SCAN0 = 3'd5;
	localparam logic [2:0] S_SCHK  = 3'd6;
	localparam logic [2:0] S_RESP  = 3'd7;

	logic [1:0] st_mem [MAX_TASKS];
	dent_t      dt_mem [MAX_TASKS];

	logic [2:0]           state_q;
	logic [CW-1:0]        count_q;
	logic [IW-1:0]        cur_q;
	logic                 started_q;
	logic                 tick_q;
	logic [IW-1:0]        last_q;
	logic [IW-1:0]        j_q;
	logic                 moved_q;
	logic [1:0]           carry_st_q;
	dent_t                carry_dt_q;
	logic [IW-1:0]        pos_q;
	logic [CW-1:0]        k_q;
	logic                 res_ok_q;
	logic                 res_none_q;
	logic [SLOT_BITS-1:0] res_slot_q;
	logic [TAG_BITS-1:0]  res_tag_q;
	logic                 out_valid_q;
	logic                 ok_q;
	logic                 none_q;
	logic [SLOT_BITS-1:0] slot_q;
	logic [TAG_BITS-1:0]  tag_q;
	logic [1:0]           rd_st_q;
	dent_t                rd_dt_q;

	logic          rd_en;
	logic [IW-1:0] ra;
	logic          st_we;
	logic          dt_we;
	logic [IW-1:0] wa;
	logic [1:0]    st_wd;
	dent_t         dt_wd;

	logic                 accept;
	logic                 out_free;
	logic [CW-1:0]        cnt_m1;
	logic [CW+2:0]        slot_w;
	logic [CW+2:0]        count_w;
	logic [IW+2:0]        pos_w;
	logic [IW-1:0]        pos_nx;
	logic [IW-1:0]        cur_nx;
	logic [IW-1:0]        j_nx;
	logic                 swap;
	logic                 found;

	function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] p, input logic [CW-1:0] n);
		logic [CW-1:0] nx;
		nx = CW'(p) + CW'(1);
		return (nx == n) ? '0 : nx[IW-1:0];
	endfunction

	assign accept   = in_valid && (state_q == S_IDLE);
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign cnt_m1   = count_q - CW'(1);
	assign slot_w   = {{CW{1'b0}}, slot};
	assign count_w  = {3'b000, count_q};
	assign pos_w    = {3'b000, pos_q};
	assign pos_nx   = wrap_inc(pos_q, count_q);
	assign cur_nx   = wrap_inc(cur_q, count_q);
	assign j_nx     = j_q + IW'(1);
	assign swap     = carry_dt_q.prio > rd_dt_q.prio;
	assign found    = (rd_st_q == ST_READY);

	always_comb begin
		rd_en = 1'b0;
		ra    = '0;
		st_we = 1'b0;
		dt_we = 1'b0;
		wa    = '0;
		st_wd = task_status;
		dt_wd = '{prio: priority_req, tag: task_tag};
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (opcode)
						OP_ADD: begin
							st_we = (count_q < CW'(MAX_TASKS));
							dt_we = st_we;
							wa    = count_q[IW-1:0];
						end
						OP_SET: begin
							st_we = (slot_w < count_w);
							wa    = slot_w[IW-1:0];
						end
						OP_TICK: begin
							st_we = started_q;
							wa    = cur_q;
							st_wd = ST_READY;
						end
						default: ;
					endcase
				end
			end
			S_SRD0: begin
				rd_en = 1'b1;
				ra    = '0;
			end
			S_SLOAD: begin
				rd_en = 1'b1;
				ra    = IW'(1);
			end
			S_SCMP: begin
				st_we = 1'b1;
				dt_we = 1'b1;
				wa    = j_q;
				st_wd = swap ? rd_st_q : carry_st_q;
				dt_wd = swap ? rd_dt_q : carry_dt_q;
				rd_en = (j_nx != last_q);
				ra    = j_q + IW'(2);
			end
			S_SEND: begin
				st_we = 1'b1;
				dt_we = 1'b1;
				wa    = last_q;
				st_wd = carry_st_q;
				dt_wd = carry_dt_q;
			end
			S_SCAN0: begin
				rd_en = 1'b1;
				ra    = pos_q;
			end
			S_SCHK: begin
				if (found) begin
					st_we = tick_q;
					wa    = pos_q;
					st_wd = ST_RUNNING;
				end else if (k_q != cnt_m1) begin
					rd_en = 1'b1;
					ra    = pos_nx;
				end
			end
			S_RESP: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			st_mem[wa] <= st_wd;
		end
		if (dt_we) begin
			dt_mem[wa] <= dt_wd;
		end
		if (rd_en) begin
			rd_st_q <= st_mem[ra];
			rd_dt_q <= dt_mem[ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			cur_q       <= '0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_ok_q   <= 1'b0;
						res_none_q <= 1'b0;
						res_slot_q <= '0;
						res_tag_q  <= '0;
						tick_q     <= 1'b0;
						k_q        <= '0;
						pos_q      <= cur_q;
						state_q    <= S_RESP;
						case (opcode)
							OP_ADD: begin
								if (count_q < CW'(MAX_TASKS)) begin
									count_q  <= count_q + CW'(1);
									res_ok_q <= 1'b1;
								end
							end
							OP_SET: begin
								res_ok_q <= (slot_w < count_w);
							end
							OP_START: begin
								if (count_q == CW'(1)) begin
									state_q <= S_SCAN0;
								end else if (count_q != '0) begin
									last_q  <= cnt_m1[IW-1:0];
									state_q <= S_SRD0;
								end
							end
							OP_TICK: begin
								if (started_q) begin
									tick_q  <= 1'b1;
									pos_q   <= cur_nx;
									state_q <= S_SCAN0;
								end
							end
							default: ;
						endcase
					end
				end
				S_SRD0: begin
					state_q <= S_SLOAD;
				end
				S_SLOAD: begin
					carry_st_q <= rd_st_q;
					carry_dt_q <= rd_dt_q;
					j_q        <= '0;
					moved_q    <= 1'b0;
					state_q    <= S_SCMP;
				end
				S_SCMP: begin
					if (swap) begin
						moved_q <= 1'b1;
					end else begin
						carry_st_q <= rd_st_q;
						carry_dt_q <= rd_dt_q;
					end
					j_q <= j_nx;
					if (j_nx == last_q) begin
						state_q <= S_SEND;
					end
				end
				S_SEND: begin
					if (!moved_q || last_q == IW'(1)) begin
						state_q <= S_SCAN0;
					end else begin
						last_q  <= last_q - IW'(1);
						state_q <= S_SRD0;
					end
				end
				S_SCAN0: begin
					state_q <= S_SCHK;
				end
				S_SCHK: begin
					if (found) begin
						cur_q      <= pos_q;
						started_q  <= 1'b1;
						res_ok_q   <= 1'b1;
						res_slot_q <= pos_w[SLOT_BITS-1:0];
						res_tag_q  <= rd_dt_q.tag;
						state_q    <= S_RESP;
					end else if (k_q == cnt_m1) begin
						started_q  <= 1'b0;
						res_none_q <= 1'b1;
						state_q    <= S_RESP;
					end else begin
						k_q   <= k_q + CW'(1);
						pos_q <= pos_nx;
					end
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESP && out_free) begin
			ok_q   <= res_ok_q;
			none_q <= res_none_q;
			slot_q <= res_slot_q;
			tag_q  <= res_tag_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign ok           = ok_q;
	assign none_ready   = none_q;
	assign running_slot = slot_q;
	assign running_tag  = tag_q;

	`PSRR_ASSERT_IMP(a_count_max, clk, arst_n, 1'b1, count_q <= CW'(MAX_TASKS))
	`PSRR_ASSERT_IMP(a_started_cur, clk, arst_n, started_q, count_q != '0 && CW'(cur_q) < count_q)
	`PSRR_ASSERT_IMP(a_rw_apart, clk, arst_n, st_we && rd_en, wa != ra)
	`PSRR_ASSERT_IMP(a_sort_bound, clk, arst_n, state_q == S_SCMP, j_q < last_q)
	`PSRR_ASSERT_NXT(a_out_load, clk, arst_n, state_q == S_RESP && out_free, out_valid_q)

endmodule

// File: bench/priority_sorted_round_robin_scheduler_core_tb.sv
// ---------------------------------------------------------------------------
// Priority-sorted round-robin scheduler core testbench
// Drives add, set status, start and tick beats into the core and checks
// every result beat against an in-bench scheduler predictor, with directed
// corner cases first and then random traffic under varying idle and stall.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module priority_sorted_round_robin_scheduler_core_tb;
	import psrr_pkg::*;

	localparam logic [1:0] ST_UNDEF = 2'd3;
	localparam int         WATCHDOG_LIMIT = 4000;
	localparam int         DRAIN_CYCLES = 150;
	localparam int         REPORT_MAX = 10;

	typedef struct packed {
		logic                 ok;
		logic                 none_ready;
		logic [SLOT_BITS-1:0] slot;
		logic [TAG_BITS-1:0]  tag;
	} grant_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [1:0]           opcode = OP_ADD;
	logic [SLOT_BITS-1:0] slot = '0;
	logic [PRIO_BITS-1:0] priority_req = '0;
	logic [1:0]           task_status = ST_BLOCKED;
	logic [TAG_BITS-1:0]  task_tag = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 ok;
	logic                 none_ready;
	logic [SLOT_BITS-1:0] running_slot;
	logic [TAG_BITS-1:0]  running_tag;

	logic [PRIO_BITS-1:0] tbl_prio [MAX_TASKS_DEF];
	logic [1:0]           tbl_stat [MAX_TASKS_DEF];
	logic [TAG_BITS-1:0]  tbl_tag  [MAX_TASKS_DEF];
	int                   tbl_count = 0;
	int                   cur_slot = 0;
	bit                   sched_started = 1'b0;

	grant_t               grant_queue [$];
	int                   mismatch_count = 0;
	int                   idle_pct = 0;
	int                   stall_pct = 0;
	int                   quiet_cycles = 0;

	priority_sorted_round_robin_scheduler_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.slot         (slot),
		.priority_req (priority_req),
		.task_status  (task_status),
		.task_tag     (task_tag),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.ok           (ok),
		.none_ready   (none_ready),
		.running_slot (running_slot),
		.running_tag  (running_tag)
	);

	always #6 clk = ~clk;

	function automatic grant_t compute_grant(input logic [1:0] op, input logic [SLOT_BITS-1:0] sl,
			input logic [PRIO_BITS-1:0] pr, input logic [1:0] st, input logic [TAG_BITS-1:0] tg);
		grant_t               g;
		int                   i;
		int                   j;
		int                   k;
		int                   pos;
		bit                   moved;
		bit                   found;
		logic [PRIO_BITS-1:0] tp;
		logic [1:0]           ts;
		logic [TAG_BITS-1:0]  tt;
		g = '0;
		if (tbl_count != 0 && cur_slot >= tbl_count)
			cur_slot = 0;
		case (op)
			OP_ADD: begin
				if (tbl_count < MAX_TASKS_DEF) begin
					tbl_prio[tbl_count] = pr;
					tbl_stat[tbl_count] = st;
					tbl_tag[tbl_count] = tg;
					tbl_count++;
					g.ok = 1'b1;
				end
			end
			OP_SET: begin
				if (int'(sl) < tbl_count) begin
					tbl_stat[sl] = st;
					g.ok = 1'b1;
				end
			end
			OP_START: begin
				if (tbl_count != 0) begin
					for (i = 0; i + 1 < tbl_count; i++) begin
						moved = 1'b0;
						for (j = 0; j + 1 < tbl_count - i; j++) begin
							if (tbl_prio[j] > tbl_prio[j+1]) begin
								tp = tbl_prio[j];
								ts = tbl_stat[j];
								tt = tbl_tag[j];
								tbl_prio[j] = tbl_prio[j+1];
								tbl_stat[j] = tbl_stat[j+1];
								tbl_tag[j] = tbl_tag[j+1];
								tbl_prio[j+1] = tp;
								tbl_stat[j+1] = ts;
								tbl_tag[j+1] = tt;
								moved = 1'b1;
							end
						end
						if (!moved)
							break;
					end
					found = 1'b0;
					pos = cur_slot;
					for (k = 0; k < tbl_count; k++) begin
						if (tbl_stat[pos] == ST_READY) begin
							found = 1'b1;
							break;
						end
						pos = (pos + 1) % tbl_count;
					end
					if (found) begin
						cur_slot = pos;
						sched_started = 1'b1;
						g.ok = 1'b1;
						g.slot = pos[SLOT_BITS-1:0];
						g.tag = tbl_tag[pos];
					end else begin
						sched_started = 1'b0;
						g.none_ready = 1'b1;
					end
				end
			end
			default: begin
				if (sched_started && tbl_count != 0) begin
					tbl_stat[cur_slot] = ST_READY;
					pos = cur_slot;
					for (k = 0; k < tbl_count; k++) begin
						pos = (pos + 1) % tbl_count;
						if (tbl_stat[pos] == ST_READY)
							break;
					end
					cur_slot = pos;
					tbl_stat[pos] = ST_RUNNING;
					g.ok = 1'b1;
					g.slot = pos[SLOT_BITS-1:0];
					g.tag = tbl_tag[pos];
				end
			end
		endcase
		return g;
	endfunction

	task automatic send_beat(input logic [1:0] op, input logic [SLOT_BITS-1:0] sl,
			input logic [PRIO_BITS-1:0] pr, input logic [1:0] st, input logic [TAG_BITS-1:0] tg,
			output grant_t g);
		int n_gap;
		n_gap = 0;
		while (idle_pct != 0 && $urandom_range(99) < idle_pct)
			n_gap++;
		if (n_gap != 0) begin
			in_valid <= 1'b0;
			repeat (n_gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		slot <= sl;
		priority_req <= pr;
		task_status <= st;
		task_tag <= tg;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		g = compute_grant(op, sl, pr, st, tg);
		grant_queue.push_back(g);
	endtask

	task automatic test_idle_table();
		grant_t g;
		send_beat(OP_START, 3'd0, 8'd0, ST_BLOCKED, $urandom, g);
		send_beat(OP_TICK, 3'd0, 8'd0, ST_BLOCKED, $urandom, g);
		send_beat(OP_SET, 3'd0, 8'd0, ST_READY, $urandom, g);
	endtask

	task automatic test_partial_table();
		grant_t g;
		send_beat(OP_ADD, 3'd7, 8'd200, ST_BLOCKED, 32'h0000_0000, g);
		send_beat(OP_ADD, 3'd0, 8'd0, ST_UNDEF, 32'hFFFF_FFFF, g);
		send_beat(OP_ADD, 3'd0, 8'd200, ST_READY, $urandom, g);
		send_beat(OP_SET, 3'd5, 8'd0, ST_READY, $urandom, g);
		send_beat(OP_START, 3'd0, 8'd0, ST_BLOCKED, $urandom, g);
		send_beat(OP_TICK, 3'd0, 8'd0, ST_BLOCKED, $urandom, g);
	endtask

	task automatic test_none_ready();
		grant_t g;
		send_beat(OP_SET, 3'd2, 8'd0, ST_BLOCKED, $urandom, g);
		send_beat(OP_START, 3'd0, 8'd0, ST_BLOCKED, $urandom, g);
		send_beat(OP_TICK, 3'd0, 8'd0, ST_BLOCKED, $urandom, g);
	endtask

	task automatic test_late_adds();
		grant_t g;
		send_beat(OP_SET, 3'd1, 8'd0, ST_READY, $urandom, g);
		send_beat(OP_START, 3'd0, 8'd0, ST_BLOCKED, $urandom, g);
		send_beat(OP_ADD, 3'd0, 8'd255, ST_READY, $urandom, g);
		send_beat(OP_TICK, 3'd0, 8'd0, ST_BLOCKED, $urandom, g);
		send_beat(OP_ADD, 3'd0, 8'd17, ST_RUNNING, $urandom, g);
		send_beat(OP_ADD, 3'd0, 8'd17, ST_READY, $urandom, g);
		send_beat(OP_ADD, 3'd0, 8'd100, ST_READY, $urandom, g);
		send_beat(OP_ADD, 3'd0, 8'd255, ST_BLOCKED, $urandom, g);
		send_beat(OP_ADD, 3'd0, 8'd1, ST_READY, $urandom, g);
		send_beat(OP_SET, 3'd7, 8'd0, ST_READY, $urandom, g);
		send_beat(OP_START, 3'd0, 8'd0, ST_BLOCKED, $urandom, g);
	endtask

	task automatic test_random_traffic(input int idle, input int stall, input int n_beats);
		grant_t     g;
		int         counted;
		int         sel;
		logic [1:0] op;
		logic [1:0] st;
		idle_pct = idle;
		stall_pct = stall;
		counted = 0;
		while (counted < n_beats) begin
			sel = $urandom_range(99);
			if (sel < 6)
				op = OP_ADD;
			else if (sel < 44)
				op = OP_SET;
			else if (sel < 56)
				op = OP_START;
			else
				op = OP_TICK;
			sel = $urandom_range(99);
			if (sel < 50)
				st = ST_READY;
			else if (sel < 85)
				st = ST_BLOCKED;
			else if (sel < 95)
				st = ST_RUNNING;
			else
				st = ST_UNDEF;
			send_beat(op, SLOT_BITS'($urandom_range(7)), PRIO_BITS'($urandom_range(255)), st,
				TAG_BITS'($urandom), g);
			if (g.ok || g.none_ready)
				counted++;
		end
	endtask

	always @(posedge clk)
		out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin
		grant_t exp_g;
		grant_t got_g;
		if (arst_n && out_valid && !out_stall) begin
			got_g = {ok, none_ready, running_slot, running_tag};
			if (grant_queue.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_MAX)
					$display("unexpected result beat: ok=%0d none_ready=%0d slot=%0d tag=%h",
						got_g.ok, got_g.none_ready, got_g.slot, got_g.tag);
			end else begin
				exp_g = grant_queue.pop_front();
				if (got_g !== exp_g) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display("result mismatch: exp ok=%0d none_ready=%0d slot=%0d tag=%h,",
							exp_g.ok, exp_g.none_ready, exp_g.slot, exp_g.tag,
							" got ok=%0d none_ready=%0d slot=%0d tag=%h",
							got_g.ok, got_g.none_ready, got_g.slot, got_g.tag);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("priority_sorted_round_robin_scheduler_core regression: fail");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_table();
		test_partial_table();
		test_none_ready();
		test_late_adds();
		test_random_traffic(0, 0, 350);
		test_random_traffic(83, 0, 350);
		test_random_traffic(0, 83, 350);
		test_random_traffic(20, 20, 350);
		in_valid <= 1'b0;
		while (grant_queue.size() != 0)
			@(posedge clk);
		stall_pct = 0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && grant_queue.size() == 0)
			$display("priority_sorted_round_robin_scheduler_core regression: pass");
		else
			$display("priority_sorted_round_robin_scheduler_core regression: fail");
		$finish;
	end

endmodule
